// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Both sample on clk and are disabled
// while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ilst_pkg.sv =====
// ----------------------------------------------------------------------------
// ilst_pkg
// Types and codes shared by the indexed list store and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilst_pkg;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 64;
  localparam int COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_SET    = 3'd4,
    CMD_GET    = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERROR = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cell update selection
  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_FROM_LOWER = 2'd2,
    OP_FROM_UPPER = 2'd3
  } cell_op_t;

  // Accepted, successful command broadcast to every cell
  typedef struct packed {
    logic push;
    logic insert;
    logic remove;
    logic set;
  } act_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } rsp_t;

endpackage

// ===== rtl/core/ilst_cell.sv =====
// ----------------------------------------------------------------------------
// ilst_cell
// One list slot. Decodes the broadcast command against its own index and
// loads the new value, takes its lower or upper neighbor, or holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilst_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 7,
  parameter int EW    = 64
) (
  input  logic                clk,
  input  ilst_pkg::act_t      act,
  input  logic [PW-1:0]       pos,
  input  logic [PW-1:0]       fill,
  input  logic                rd_en,
  input  logic [PW-1:0]       rd_idx,
  input  logic [EW-1:0]       wr_value,
  input  logic [EW-1:0]       lower_value,
  input  logic [EW-1:0]       upper_value,
  output logic [EW-1:0]       value,
  output logic [EW-1:0]       tap
);

  localparam logic [PW-1:0] IDX    = PW'(INDEX);
  localparam logic [PW:0]   IDX_P1 = (PW+1)'(INDEX + 1);

  ilst_pkg::cell_op_t op;

  always_comb begin
    op = ilst_pkg::OP_HOLD;
    if ((act.push && IDX == fill) || ((act.insert || act.set) && IDX == pos)) begin
      op = ilst_pkg::OP_LOAD;
    end else if (act.insert && IDX > pos && IDX <= fill) begin
      op = ilst_pkg::OP_FROM_LOWER;
    end else if (act.remove && IDX >= pos && IDX_P1 < {1'b0, fill}) begin
      op = ilst_pkg::OP_FROM_UPPER;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      ilst_pkg::OP_LOAD:       value <= wr_value;
      ilst_pkg::OP_FROM_LOWER: value <= lower_value;
      ilst_pkg::OP_FROM_UPPER: value <= upper_value;
      default:                 value <= value;
    endcase
  end

  // Read tap is zero unless this slot is addressed; the top ORs all taps
  assign tap = (rd_en && rd_idx == IDX) ? value : '0;

endmodule

// ===== rtl/core/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered list of fixed-width entries held in a row of cells.
// Push, pop, insert, remove, set, get and clear each give one response.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   ilst_pkg::req_t (cmd, position, value)
//   rsp      out  rsp_valid/rsp_stall   ilst_pkg::rsp_t (read, status, count)
//
// All cells shift in parallel on the accepting edge, and the response is
// captured in the output register on that same edge.
// A new request is taken every cycle unless a held response is stalled.
// Reset empties the list; entry contents are not cleared.
// Failed requests leave the list unchanged and return a zero read value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module indexed_list_store #(
  parameter int DEPTH       = 64,
  parameter int ENTRY_WIDTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  ilst_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ilst_pkg::rsp_t  rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > ilst_pkg::POS_W) ? CW : ilst_pkg::POS_W;

  logic [CW-1:0]          fill;
  logic [CW-1:0]          fill_next;
  logic                   req_acc;
  logic                   full;
  logic [PW-1:0]          fillx;
  logic [PW-1:0]          posx;
  ilst_pkg::status_t      status_next;
  ilst_pkg::act_t         act_ok;
  ilst_pkg::act_t         act;
  logic                   rd_en;
  logic [PW-1:0]          rd_idx;
  logic [ENTRY_WIDTH-1:0] wr_value;
  logic [ENTRY_WIDTH-1:0] rd_value;
  logic [ENTRY_WIDTH-1:0] cell_value [DEPTH];
  logic [ENTRY_WIDTH-1:0] cell_tap   [DEPTH];
  logic                   req_err;
  logic                   push_ok;

  assign req_stall = rsp_valid && rsp_stall;
  assign req_acc   = req_valid && !req_stall;
  assign full      = (fill == CW'(DEPTH));
  assign fillx     = PW'(fill);
  assign posx      = PW'(req.position);
  assign wr_value  = req.entry_value[ENTRY_WIDTH-1:0];

  always_comb begin
    status_next = ilst_pkg::ST_OK;
    act_ok      = '0;
    rd_en       = 1'b0;
    rd_idx      = posx;
    fill_next   = fill;
    case (req.cmd)
      ilst_pkg::CMD_PUSH: begin
        if (full) begin
          status_next = ilst_pkg::ST_FULL;
        end else begin
          act_ok.push = 1'b1;
          fill_next   = fill + 1'b1;
        end
      end
      ilst_pkg::CMD_POP: begin
        if (fill == '0) begin
          status_next = ilst_pkg::ST_ERROR;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = fillx - 1'b1;
          fill_next = fill - 1'b1;
        end
      end
      ilst_pkg::CMD_INSERT: begin
        if (posx > fillx) begin
          status_next = ilst_pkg::ST_ERROR;
        end else if (full) begin
          status_next = ilst_pkg::ST_FULL;
        end else begin
          act_ok.insert = 1'b1;
          fill_next     = fill + 1'b1;
        end
      end
      ilst_pkg::CMD_REMOVE: begin
        if (posx >= fillx) begin
          status_next = ilst_pkg::ST_ERROR;
        end else begin
          act_ok.remove = 1'b1;
          rd_en         = 1'b1;
          fill_next     = fill - 1'b1;
        end
      end
      ilst_pkg::CMD_SET: begin
        if (posx >= fillx) begin
          status_next = ilst_pkg::ST_ERROR;
        end else begin
          act_ok.set = 1'b1;
        end
      end
      ilst_pkg::CMD_GET: begin
        if (posx >= fillx) begin
          status_next = ilst_pkg::ST_ERROR;
        end else begin
          rd_en = 1'b1;
        end
      end
      ilst_pkg::CMD_CLEAR: begin
        fill_next = '0;
      end
      default: begin
        status_next = ilst_pkg::ST_ERROR;
      end
    endcase
  end

  assign act = req_acc ? act_ok : '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] lower_value;
    logic [ENTRY_WIDTH-1:0] upper_value;

    if (i == 0) begin : g_first
      assign lower_value = '0;
    end else begin : g_lower
      assign lower_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_value = '0;
    end else begin : g_upper
      assign upper_value = cell_value[i+1];
    end

    ilst_cell #(
      .INDEX (i),
      .PW    (PW),
      .EW    (ENTRY_WIDTH)
    ) u_cell (
      .clk         (clk),
      .act         (act),
      .pos         (posx),
      .fill        (fillx),
      .rd_en       (rd_en),
      .rd_idx      (rd_idx),
      .wr_value    (wr_value),
      .lower_value (lower_value),
      .upper_value (upper_value),
      .value       (cell_value[i]),
      .tap         (cell_tap[i])
    );
  end

  // taps are one-hot gated, so the read is a plain OR
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_value = rd_value | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_acc) begin
        fill      <= fill_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      rsp.read_value <= ilst_pkg::DATA_W'(rd_value);
      rsp.status     <= status_next;
      rsp.count      <= ilst_pkg::COUNT_W'(fill_next);
      rsp.empty_res  <= (fill_next == '0);
    end
  end

  assign req_err = req_acc && (status_next != ilst_pkg::ST_OK);
  assign push_ok = req_acc && act_ok.push;

  `ASSERT_ALWAYS(a_fill_bound, fill <= CW'(DEPTH), "fill exceeds capacity")
  `ASSERT_NEXT(a_err_keeps_fill, req_err, $stable(fill), "failed request changed fill")
  `ASSERT_NEXT(a_push_grows, push_ok, fill == CW'($past(fill) + 1'b1), "push did not grow list")
  `ASSERT_NEXT(a_empty_flag, req_acc, rsp.empty_res == (fill == '0), "empty flag disagrees")

endmodule
